@@ src/vfc_pkg.sv @@
// shared types, codes, microcode program and face tables of the voxel mesher
`default_nettype none
package vfc_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_MESH  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [2:0] FACE_TOP    = 3'd0;
  localparam logic [2:0] FACE_BOTTOM = 3'd1;
  localparam logic [2:0] FACE_LEFT   = 3'd2;
  localparam logic [2:0] FACE_RIGHT  = 3'd3;
  localparam logic [2:0] FACE_FRONT  = 3'd4;
  localparam logic [2:0] FACE_BACK   = 3'd5;

  localparam int VERTS_PER_FACE = 4;
  localparam int COUNT_BITS     = 17;
  localparam int OUT_TYPE_BITS  = 8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_CLRCNT,
    ST_RSELF,
    ST_CTYPE,
    ST_RNB,
    ST_CNB,
    ST_EMIT
  } step_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_CLEAR_WR,
    MEM_WR,
    MEM_RD_SELF,
    MEM_RD_NB
  } mem_op_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_CAP_TYPE,
    DP_CAP_NB,
    DP_EMIT,
    DP_CLR_CNT
  } dp_op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_CLR_BUSY,
    COND_DISPATCH,
    COND_TYPE_ZERO,
    COND_NB_MORE,
    COND_EMIT_BUSY
  } cond_t;

  typedef struct packed {
    logic    accept;
    mem_op_t mem_op;
    dp_op_t  dp_op;
    cond_t   cond;
    step_t   next_step;
    step_t   jump_step;
  } ctrl_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] mode;
    logic       in_range;
    logic       clr_last;
    logic       type_zero;
    logic       nb_last;
    logic       emit_done;
  } stat_t;

  // microcode program, one control word per step
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    w = '{accept: 1'b0, mem_op: MEM_NONE, dp_op: DP_NONE, cond: COND_NEVER,
          next_step: ST_IDLE, jump_step: ST_IDLE};
    case (step)
      ST_CLEAR: begin
        w.mem_op    = MEM_CLEAR_WR;
        w.cond      = COND_CLR_BUSY;
        w.jump_step = ST_CLEAR;
      end
      ST_IDLE: begin
        w.accept = 1'b1;
        w.cond   = COND_DISPATCH;
      end
      ST_WRITE:  w.mem_op = MEM_WR;
      ST_CLRCNT: w.dp_op  = DP_CLR_CNT;
      ST_RSELF: begin
        w.mem_op    = MEM_RD_SELF;
        w.next_step = ST_CTYPE;
      end
      ST_CTYPE: begin
        w.dp_op     = DP_CAP_TYPE;
        w.cond      = COND_TYPE_ZERO;
        w.next_step = ST_RNB;
      end
      ST_RNB: begin
        w.mem_op    = MEM_RD_NB;
        w.next_step = ST_CNB;
      end
      ST_CNB: begin
        w.dp_op     = DP_CAP_NB;
        w.cond      = COND_NB_MORE;
        w.jump_step = ST_RNB;
        w.next_step = ST_EMIT;
      end
      ST_EMIT: begin
        w.dp_op     = DP_EMIT;
        w.cond      = COND_EMIT_BUSY;
        w.jump_step = ST_EMIT;
      end
      default: w.next_step = ST_IDLE;
    endcase
    return w;
  endfunction

  // corner offsets {dx, dy, dz} per face and corner
  function automatic logic [2:0] corner_offset(input logic [2:0] face,
                                               input logic [1:0] corner);
    logic [2:0] r;
    r = 3'b000;
    case (face)
      FACE_TOP: begin
        case (corner)
          2'd0: r = 3'b010;
          2'd1: r = 3'b011;
          2'd2: r = 3'b111;
          default: r = 3'b110;
        endcase
      end
      FACE_BOTTOM: begin
        case (corner)
          2'd0: r = 3'b001;
          2'd1: r = 3'b000;
          2'd2: r = 3'b100;
          default: r = 3'b101;
        endcase
      end
      FACE_LEFT: begin
        case (corner)
          2'd0: r = 3'b001;
          2'd1: r = 3'b011;
          2'd2: r = 3'b010;
          default: r = 3'b000;
        endcase
      end
      FACE_RIGHT: begin
        case (corner)
          2'd0: r = 3'b100;
          2'd1: r = 3'b110;
          2'd2: r = 3'b111;
          default: r = 3'b101;
        endcase
      end
      FACE_FRONT: begin
        case (corner)
          2'd0: r = 3'b000;
          2'd1: r = 3'b010;
          2'd2: r = 3'b110;
          default: r = 3'b100;
        endcase
      end
      FACE_BACK: begin
        case (corner)
          2'd0: r = 3'b101;
          2'd1: r = 3'b111;
          2'd2: r = 3'b011;
          default: r = 3'b001;
        endcase
      end
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/vfc_sequencer.sv @@
// microcode sequencer: step counter, control store lookup and jumps
`default_nettype none
module vfc_sequencer
  import vfc_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  stat_t stat,
  output ctrl_t ctrl,
  output step_t step
);

  step_t step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_CLEAR;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = ucode_rom(step);
  end

  always_comb begin
    step_next = ctrl.next_step;
    case (ctrl.cond)
      COND_NEVER:     step_next = ctrl.next_step;
      COND_CLR_BUSY:  step_next = stat.clr_last ? ctrl.next_step : ctrl.jump_step;
      COND_TYPE_ZERO: step_next = stat.type_zero ? ctrl.jump_step : ctrl.next_step;
      COND_NB_MORE:   step_next = stat.nb_last ? ctrl.next_step : ctrl.jump_step;
      COND_EMIT_BUSY: step_next = stat.emit_done ? ctrl.next_step : ctrl.jump_step;
      COND_DISPATCH: begin
        // multiway branch on the incoming mode
        if (stat.in_valid) begin
          case (stat.mode)
            MODE_WRITE: step_next = stat.in_range ? ST_WRITE : ST_IDLE;
            MODE_MESH:  step_next = stat.in_range ? ST_RSELF : ST_IDLE;
            MODE_CLEAR: step_next = ST_CLRCNT;
            default:    step_next = ST_IDLE;
          endcase
        end else begin
          step_next = ctrl.next_step;
        end
      end
      default: step_next = ctrl.next_step;
    endcase
  end

endmodule
`default_nettype wire

@@ src/vfc_datapath.sv @@
// datapath: voxel memory, neighbor address logic, face mask and vertex output register
`default_nettype none
module vfc_datapath
  import vfc_pkg::*;
#(
  parameter int EDGE_CELLS = 16,
  parameter int TYPE_BITS  = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  ctrl_t                        ctrl,
  output stat_t                        stat,
  input  wire                          in_valid,
  input  wire  [1:0]                   mode,
  input  wire  [3:0]                   voxel_x,
  input  wire  [3:0]                   voxel_y,
  input  wire  [3:0]                   voxel_z,
  input  wire  [7:0]                   new_type,
  output logic [4:0]                   corner_x,
  output logic [4:0]                   corner_y,
  output logic [4:0]                   corner_z,
  output logic                         tex_u,
  output logic                         tex_v,
  output logic [OUT_TYPE_BITS-1:0]     cell_type,
  output logic [2:0]                   face_kind,
  output logic [COUNT_BITS-1:0]        vertex_number,
  output logic                         last_vertex,
  output logic                         out_valid,
  input  wire                          out_stall
);

  localparam int CELLS  = EDGE_CELLS * EDGE_CELLS * EDGE_CELLS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [TYPE_BITS-1:0] mem [CELLS];
  logic [TYPE_BITS-1:0] rdata;

  logic [3:0]            cur_x, cur_y, cur_z;
  logic [7:0]            cur_new;
  logic [TYPE_BITS-1:0]  cur_cell;
  logic [5:0]            mask;
  logic [2:0]            face;
  logic [1:0]            corner;
  logic [COUNT_BITS-1:0] vcount;
  logic                  nb_out;
  logic [ADDR_W-1:0]     clr_addr;

  logic                  accept;
  logic [4:0]            nb_x, nb_y, nb_z;
  logic                  nb_outside;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [TYPE_BITS-1:0]  mem_wdata;
  logic                  face_on, out_free, out_load, later_none;
  logic [5:0]            higher;
  logic [2:0]            offs;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] cx,
                                                  input logic [4:0] cy,
                                                  input logic [4:0] cz);
    logic [31:0] a;
    a = 32'(cx) + 32'(cz) * EDGE_CELLS + 32'(cy) * EDGE_CELLS * EDGE_CELLS;
    return a[ADDR_W-1:0];
  endfunction

  assign accept = in_valid && ctrl.accept;

  // neighbor of the current voxel across the face under test
  always_comb begin
    nb_x = {1'b0, cur_x};
    nb_y = {1'b0, cur_y};
    nb_z = {1'b0, cur_z};
    nb_outside = 1'b0;
    case (face)
      FACE_TOP: begin
        nb_y = {1'b0, cur_y} + 5'd1;
        nb_outside = 32'(nb_y) >= EDGE_CELLS;
      end
      FACE_BOTTOM: begin
        nb_y = {1'b0, cur_y} - 5'd1;
        nb_outside = cur_y == 4'd0;
      end
      FACE_LEFT: begin
        nb_x = {1'b0, cur_x} - 5'd1;
        nb_outside = cur_x == 4'd0;
      end
      FACE_RIGHT: begin
        nb_x = {1'b0, cur_x} + 5'd1;
        nb_outside = 32'(nb_x) >= EDGE_CELLS;
      end
      FACE_FRONT: begin
        nb_z = {1'b0, cur_z} - 5'd1;
        nb_outside = cur_z == 4'd0;
      end
      FACE_BACK: begin
        nb_z = {1'b0, cur_z} + 5'd1;
        nb_outside = 32'(nb_z) >= EDGE_CELLS;
      end
      default: nb_outside = 1'b1;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_raddr = cell_addr({1'b0, cur_x}, {1'b0, cur_y}, {1'b0, cur_z});
    case (ctrl.mem_op)
      MEM_CLEAR_WR: mem_we = 1'b1;
      MEM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr({1'b0, cur_x}, {1'b0, cur_y}, {1'b0, cur_z});
        mem_wdata = TYPE_BITS'(cur_new);
      end
      MEM_RD_NB: mem_raddr = cell_addr(nb_x, nb_y, nb_z);
      default:   mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // vertex emission
  assign face_on    = mask[face];
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = (ctrl.dp_op == DP_EMIT) && face_on && out_free;
  assign higher     = mask >> face;
  assign later_none = higher[5:1] == 5'd0;
  assign offs       = corner_offset(face, corner);

  always_comb begin
    stat.in_valid  = in_valid;
    stat.mode      = mode;
    stat.in_range  = (32'(voxel_x) < EDGE_CELLS) && (32'(voxel_y) < EDGE_CELLS)
                     && (32'(voxel_z) < EDGE_CELLS);
    stat.clr_last  = clr_addr == ADDR_W'(CELLS - 1);
    stat.type_zero = rdata == '0;
    stat.nb_last   = face == FACE_BACK;
    stat.emit_done = (face == FACE_BACK) && (!face_on || (corner == 2'd3 && out_load));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x   <= voxel_x;
      cur_y   <= voxel_y;
      cur_z   <= voxel_z;
      cur_new <= new_type;
    end
    if (ctrl.dp_op == DP_CAP_TYPE) begin
      cur_cell <= rdata;
    end
    if (ctrl.mem_op == MEM_RD_NB) begin
      nb_out <= nb_outside;
    end
    if (out_load) begin
      corner_x      <= {1'b0, cur_x} + {4'd0, offs[2]};
      corner_y      <= {1'b0, cur_y} + {4'd0, offs[1]};
      corner_z      <= {1'b0, cur_z} + {4'd0, offs[0]};
      tex_u         <= corner[1];
      tex_v         <= ~(corner[0] ^ corner[1]);
      cell_type     <= OUT_TYPE_BITS'(cur_cell);
      face_kind     <= face;
      vertex_number <= vcount + COUNT_BITS'(corner);
      last_vertex   <= (corner == 2'd3) && later_none;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      vcount    <= '0;
      face      <= FACE_TOP;
      corner    <= 2'd0;
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.mem_op == MEM_CLEAR_WR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (ctrl.dp_op == DP_CLR_CNT) begin
        vcount <= '0;
      end else if (out_load && corner == 2'd3) begin
        vcount <= vcount + COUNT_BITS'(VERTS_PER_FACE);
      end
      case (ctrl.dp_op)
        DP_CAP_TYPE: face <= FACE_TOP;
        DP_CAP_NB: begin
          // face is exposed when the neighbor is outside or empty
          mask[face] <= nb_out || (rdata == '0);
          face       <= (face == FACE_BACK) ? FACE_TOP : face + 3'd1;
          corner     <= 2'd0;
        end
        DP_EMIT: begin
          if (!face_on) begin
            face <= face + 3'd1;
          end else if (out_load) begin
            corner <= corner + 2'd1;
            if (corner == 2'd3) begin
              face <= face + 3'd1;
            end
          end
        end
        default: face <= face;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/voxel_face_culling_mesher.sv @@
// voxel face culling mesher: cubic chunk store with a microcoded face emitter
// Input channel (in_valid / in_stall) carries one command transaction: mode 0
// stores new_type at (voxel_x, voxel_y, voxel_z), mode 1 meshes that voxel,
// mode 2 clears the running vertex counter. Out-of-chunk write or mesh
// commands and mode 3 are taken and dropped.
// Output channel (out_valid / out_stall) gives one vertex per transaction,
// four per exposed face, faces in top, bottom, left, right, front, back order;
// last_vertex marks the final vertex of a mesh command.
// Sequence: write and counter-clear commands run their WRITE or CLRCNT step
// after being taken. A mesh command reads the voxel itself and ends for an empty
// voxel; else it reads each neighbor (one memory read per neighbor, two steps
// each), then emits one vertex per cycle unless the receiver stalls.
// The rate is set by the single read port of the voxel memory and the
// one-vertex output register.
// After reset a clearing pass writes every entry to empty, one per cycle, over
// all EDGE_CELLS^3 entries (4096 by default) with in_stall held high.
// A stalled vertex holds in the output register; the next command is still
// taken, and emission pauses until the register frees.
`default_nettype none
module voxel_face_culling_mesher
  import vfc_pkg::*;
#(
  parameter int EDGE_CELLS = 16,
  parameter int TYPE_BITS  = 8
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [1:0]               mode,
  input  wire  [3:0]               voxel_x,
  input  wire  [3:0]               voxel_y,
  input  wire  [3:0]               voxel_z,
  input  wire  [7:0]               new_type,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [4:0]               corner_x,
  output logic [4:0]               corner_y,
  output logic [4:0]               corner_z,
  output logic                     tex_u,
  output logic                     tex_v,
  output logic [OUT_TYPE_BITS-1:0] cell_type,
  output logic [2:0]               face_kind,
  output logic [COUNT_BITS-1:0]    vertex_number,
  output logic                     last_vertex
);

  ctrl_t ctrl;
  stat_t stat;
  step_t step;

  vfc_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl),
    .step (step)
  );

  vfc_datapath #(
    .EDGE_CELLS (EDGE_CELLS),
    .TYPE_BITS  (TYPE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .in_valid      (in_valid),
    .mode          (mode),
    .voxel_x       (voxel_x),
    .voxel_y       (voxel_y),
    .voxel_z       (voxel_z),
    .new_type      (new_type),
    .corner_x      (corner_x),
    .corner_y      (corner_y),
    .corner_z      (corner_z),
    .tex_u         (tex_u),
    .tex_v         (tex_v),
    .cell_type     (cell_type),
    .face_kind     (face_kind),
    .vertex_number (vertex_number),
    .last_vertex   (last_vertex),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  assign in_stall = !ctrl.accept;

  // no command taken while the memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (step == ST_CLEAR) |-> in_stall)
    else $error("command accepted during clearing pass");

  // face base is a multiple of four, so the low bits follow the uv corner
  a_vnum_matches_uv: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (vertex_number[1:0] == {tex_u, ~tex_v ^ tex_u}))
    else $error("vertex number out of step with corner");

  // last vertex can only be the fourth corner of a face
  a_last_on_corner3: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_vertex) |-> (tex_u && tex_v))
    else $error("last vertex on wrong corner");

  // a new vertex only appears just after the emission step
  a_emit_from_mesh: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> ($past(step) == ST_EMIT))
    else $error("vertex produced outside emission step");

endmodule
`default_nettype wire
